[hdl/lksp_pkg.sv]
// Package for the login/keepalive stream parser: item, result and command
// types, phase and kind codes, and the keepalive pattern table.
// No dependencies.
package lksp_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_FLUSH   = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Result kind codes
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_LOGIN  = 3'd1;
    localparam logic [2:0] KIND_ACCEPT = 3'd2;
    localparam logic [2:0] KIND_REJECT = 3'd3;
    localparam logic [2:0] KIND_ALIVE  = 3'd4;
    localparam logic [2:0] KIND_CHUNK  = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    // Parser phases
    localparam logic [3:0] PH_INITIAL = 4'd0;
    localparam logic [3:0] PH_LOGIN   = 4'd1;
    localparam logic [3:0] PH_STREAM  = 4'd2;
    localparam logic [3:0] PH_MA      = 4'd3;
    localparam logic [3:0] PH_ML      = 4'd4;
    localparam logic [3:0] PH_MI      = 4'd5;
    localparam logic [3:0] PH_MV      = 4'd6;
    localparam logic [3:0] PH_ME      = 4'd7;
    localparam logic [3:0] PH_MGT     = 4'd8;
    localparam logic [3:0] PH_ERROR   = 4'd9;

    // Characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_E     = 8'h45;

    localparam logic [2:0] FIELD_MAX    = 3'd7;
    localparam logic [2:0] LOGIN_FIELDS = 3'd3;
    localparam logic [2:0] ALIVE_PREFIX = 3'd6;

    // Command queue geometry
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_in;
    } req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_out;
        logic [2:0] field_number;
        logic       after_colon;
        logic       last;
    } res_t;

    // One command per accepted item that causes results: an optional replay
    // of prefix_len keepalive pattern bytes, then one final result.
    typedef struct packed {
        logic [2:0] prefix_len;
        logic [2:0] kind;
        logic [7:0] byte_val;
        logic [2:0] field_number;
        logic       after_colon;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] alive_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_LT;
            3'd1:    ch = CH_A;
            3'd2:    ch = CH_L;
            3'd3:    ch = CH_I;
            3'd4:    ch = CH_V;
            3'd5:    ch = CH_E;
            default: ch = CH_GT;
        endcase
        return ch;
    endfunction

endpackage

[hdl/lksp_front.sv]
// Front end of the parser: phase tracking and classification of each
// accepted item into one command for the back end. Uses lksp_pkg.
module lksp_front
    import lksp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output logic cmd_push,
    output cmd_t cmd
);

    logic [3:0] phase_reg, phase_next;
    logic       pending_reg, pending_next;
    logic [2:0] semis_reg, semis_next;
    logic       colon_reg, colon_next;
    logic       has_cmd;
    logic [2:0] matched;

    assign matched = 3'(phase_reg - PH_MA) + 3'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        semis_next   = semis_reg;
        colon_next   = colon_reg;
        has_cmd      = 1'b0;
        cmd          = '0;
        case (req.func)
            FUNC_RESTART:
            begin
                phase_next   = PH_INITIAL;
                pending_next = 1'b0;
                semis_next   = '0;
                colon_next   = 1'b0;
            end
            FUNC_FLUSH:
            begin
                if (phase_reg == PH_STREAM && pending_reg)
                begin
                    has_cmd      = 1'b1;
                    cmd.kind     = KIND_CHUNK;
                    pending_next = 1'b0;
                end
            end
            FUNC_BYTE:
            begin
                case (phase_reg) inside
                    PH_INITIAL:
                    begin
                        if (req.byte_in == CH_LT)
                        begin
                            phase_next = PH_LOGIN;
                            semis_next = '0;
                            colon_next = 1'b0;
                        end
                        else
                            phase_next = PH_ERROR;
                    end
                    PH_LOGIN:
                    begin
                        has_cmd = 1'b1;
                        if (req.byte_in == CH_GT)
                        begin
                            if (semis_reg == LOGIN_FIELDS)
                            begin
                                cmd.kind     = KIND_ACCEPT;
                                phase_next   = PH_STREAM;
                                pending_next = 1'b0;
                            end
                            else
                            begin
                                cmd.kind   = KIND_REJECT;
                                phase_next = PH_INITIAL;
                            end
                            semis_next = '0;
                            colon_next = 1'b0;
                        end
                        else
                        begin
                            cmd.kind         = KIND_LOGIN;
                            cmd.byte_val     = req.byte_in;
                            cmd.field_number = semis_reg;
                            cmd.after_colon  = colon_reg;
                            if (req.byte_in == CH_SEMI)
                            begin
                                if (semis_reg != FIELD_MAX)
                                    semis_next = semis_reg + 3'd1;
                                colon_next = 1'b0;
                            end
                            else if (req.byte_in == CH_COLON)
                                colon_next = 1'b1;
                        end
                    end
                    PH_STREAM:
                    begin
                        if (req.byte_in == CH_LT)
                            phase_next = PH_MA;
                        else
                        begin
                            has_cmd      = 1'b1;
                            cmd.kind     = KIND_DATA;
                            cmd.byte_val = req.byte_in;
                            pending_next = 1'b1;
                        end
                    end
                    [PH_MA:PH_ME]:
                    begin
                        if (req.byte_in == alive_char(matched))
                            phase_next = phase_reg + 4'd1;
                        else
                        begin
                            // broken match: replay the prefix, then the byte
                            has_cmd        = 1'b1;
                            cmd.prefix_len = matched;
                            cmd.kind       = KIND_DATA;
                            cmd.byte_val   = req.byte_in;
                            pending_next   = 1'b1;
                            phase_next     = PH_STREAM;
                        end
                    end
                    PH_MGT:
                    begin
                        has_cmd = 1'b1;
                        if (req.byte_in == CH_GT)
                            cmd.kind = KIND_ALIVE;
                        else
                        begin
                            cmd.prefix_len = ALIVE_PREFIX;
                            cmd.kind       = KIND_DATA;
                            cmd.byte_val   = req.byte_in;
                            pending_next   = 1'b1;
                        end
                        phase_next = PH_STREAM;
                    end
                    default:
                    begin
                        // error phase: drop the byte, report once
                        has_cmd      = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        pending_next = 1'b0;
                        phase_next   = PH_STREAM;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_push = accept && has_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_INITIAL;
            pending_reg <= 1'b0;
            semis_reg   <= '0;
            colon_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            semis_reg   <= semis_next;
            colon_reg   <= colon_next;
        end
    end

endmodule

[hdl/lksp_cmd_fifo.sv]
// Short command queue between the parser front end and the result back end.
// Uses lksp_pkg.
module lksp_cmd_fifo
    import lksp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_data,
    input  logic      rd_en,
    output cmd_t      rd_data,
    output q_status_t status
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + CMD_CNT_W'(1);
                2'b01:   count_reg <= count_reg - CMD_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hdl/lksp_back.sv]
// Back end: expands each command into its results, one per cycle while the
// output slot is free or being taken, into the output register. Uses lksp_pkg.
module lksp_back
    import lksp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      head_pop,
    input  logic      pop,
    output logic      empty,
    output res_t      result
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    res_t       result_reg;
    res_t       res_next;
    logic       step;
    logic       in_prefix;

    // Advance when a command waits and the output slot is free or being taken
    assign step      = !q_status.empty && (!valid_reg || pop);
    assign in_prefix = (idx_reg < head.prefix_len);
    assign head_pop  = step && !in_prefix;

    always_comb
    begin
        res_next = '0;
        if (in_prefix)
        begin
            res_next.kind     = KIND_DATA;
            res_next.byte_out = alive_char(idx_reg);
        end
        else
        begin
            res_next.kind         = head.kind;
            res_next.byte_out     = head.byte_val;
            res_next.field_number = head.field_number;
            res_next.after_colon  = head.after_colon;
            res_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= in_prefix ? idx_reg + 3'd1 : 3'd0;
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= res_next;
    end

    assign empty  = !valid_reg;
    assign result = result_reg;

endmodule

[hdl/login_keepalive_stream_parser_top.sv]
// Top level of the login/keepalive stream parser.
// Depends on lksp_pkg, lksp_front, lksp_cmd_fifo and lksp_back.
//
// Usage:
//   Requests enter through a queue-like port: present request and raise
//   push; the request is taken at a rising edge with push high and full low.
//   A request carries func (byte, chunk-end flush, restart) and byte_in.
//   Results leave the same way: while empty is low the oldest result sits on
//   result; it is taken at a rising edge with pop high and empty low.
//   result.last marks the final result caused by one request.
// Results: a request that causes results has its command enter the queue at
//   the accepting edge; the back end then loads the output register from the
//   queue head once the output slot is free. Requests that cause no result
//   only update the parser phase.
// Throughput: one request per cycle while full is low; the back end emits
//   one result per cycle while pop is high. A broken keepalive match emits
//   up to seven results from one request; during that burst the four-entry
//   command queue can fill and raise full until the back end catches up.
// Reset: rst_n low clears the phase to initial, all login tags and pending
//   data, empties the command queue and the output register.
// Stall: if the receiver holds pop low, the output register holds its result,
//   the back end waits, the command queue fills and then full holds requests.
module login_keepalive_stream_parser_top
    import lksp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t request,
    output logic empty,
    input  logic pop,
    output res_t result
);

    q_status_t q_status;
    logic      accept;
    logic      cmd_push;
    cmd_t      cmd;
    cmd_t      head;
    logic      head_pop;

    // Take a request whenever the command queue has room
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    lksp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (request),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    lksp_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (head_pop),
        .rd_data (head),
        .status  (q_status)
    );

    lksp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .head_pop (head_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for login_keepalive_stream_parser_top: directed and random
// byte streams, an internal behavioral predictor and a scoreboard of parsed results.
// Depends on lksp_pkg and the parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lksp_pkg::*;

    // func code the parser ignores; it is not named in the package
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    // "<ALIVE" packed MSB first; the closing '>' is checked on its own
    localparam logic [47:0] ALIVE_WORD = {CH_LT, CH_A, CH_L, CH_I, CH_V, CH_E};

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    req_t request = '0;
    logic empty;
    logic pop = 1'b0;
    res_t result;

    // Parser state as the predictor sees it
    logic [3:0] parse_phase = PH_INITIAL;
    logic       parse_pending = 1'b0;
    logic [2:0] parse_semis = 3'd0;
    logic       parse_colon = 1'b0;

    // Results the parser owes, oldest first
    res_t parsed_q[$];

    int mismatches = 0;
    int stuck_cycles = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int pop_hold = 0;

    login_keepalive_stream_parser_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] pattern_byte(input int idx);
        return ALIVE_WORD[8 * (5 - idx) +: 8];
    endfunction

    function automatic res_t make_result(input logic [2:0] kind, input logic [7:0] b,
                                         input logic [2:0] fld, input logic col);
        res_t r;
        r.kind = kind;
        r.byte_out = b;
        r.field_number = fld;
        r.after_colon = col;
        r.last = 1'b0;
        return r;
    endfunction

    // Append one owed result at the tail of the scoreboard
    function automatic void owe_result(input logic [2:0] kind, input logic [7:0] b,
                                       input logic [2:0] fld, input logic col);
        parsed_q.insert(parsed_q.size(), make_result(kind, b, fld, col));
    endfunction

    // Advance the predicted parser by one accepted transaction and queue the
    // results it causes; the final one of them carries last.
    function automatic void parse_request(input req_t rq);
        res_t       tail;
        int         matched;
        int         n_before;
        logic [7:0] c;
        c = rq.byte_in;
        n_before = parsed_q.size();
        case (rq.func)
            FUNC_RESTART:
            begin
                parse_phase = PH_INITIAL;
                parse_pending = 1'b0;
                parse_semis = 3'd0;
                parse_colon = 1'b0;
            end
            FUNC_FLUSH:
            begin
                if (parse_phase == PH_STREAM && parse_pending)
                begin
                    owe_result(KIND_CHUNK, 8'd0, 3'd0, 1'b0);
                    parse_pending = 1'b0;
                end
            end
            FUNC_BYTE:
            begin
                case (parse_phase)
                    PH_INITIAL:
                    begin
                        if (c == CH_LT)
                        begin
                            parse_phase = PH_LOGIN;
                            parse_semis = 3'd0;
                            parse_colon = 1'b0;
                        end
                        else
                            parse_phase = PH_ERROR;
                    end
                    PH_LOGIN:
                    begin
                        if (c == CH_GT)
                        begin
                            if (parse_semis == LOGIN_FIELDS)
                            begin
                                owe_result(KIND_ACCEPT, 8'd0, 3'd0, 1'b0);
                                parse_phase = PH_STREAM;
                                parse_pending = 1'b0;
                            end
                            else
                            begin
                                owe_result(KIND_REJECT, 8'd0, 3'd0, 1'b0);
                                parse_phase = PH_INITIAL;
                            end
                            parse_semis = 3'd0;
                            parse_colon = 1'b0;
                        end
                        else
                        begin
                            // separators go out with the tags in force before them
                            owe_result(KIND_LOGIN, c, parse_semis, parse_colon);
                            if (c == CH_SEMI)
                            begin
                                if (parse_semis != FIELD_MAX)
                                    parse_semis = parse_semis + 3'd1;
                                parse_colon = 1'b0;
                            end
                            else if (c == CH_COLON)
                                parse_colon = 1'b1;
                        end
                    end
                    PH_STREAM:
                    begin
                        if (c == CH_LT)
                            parse_phase = PH_MA;
                        else
                        begin
                            owe_result(KIND_DATA, c, 3'd0, 1'b0);
                            parse_pending = 1'b1;
                        end
                    end
                    PH_MA, PH_ML, PH_MI, PH_MV, PH_ME:
                    begin
                        matched = int'(parse_phase - PH_MA) + 1;
                        if (c == pattern_byte(matched))
                            parse_phase = parse_phase + 4'd1;
                        else
                        begin
                            // replay the matched prefix, then the breaking byte
                            for (int i = 0; i < matched; i++)
                                owe_result(KIND_DATA, pattern_byte(i), 3'd0, 1'b0);
                            owe_result(KIND_DATA, c, 3'd0, 1'b0);
                            parse_pending = 1'b1;
                            parse_phase = PH_STREAM;
                        end
                    end
                    PH_MGT:
                    begin
                        if (c == CH_GT)
                            owe_result(KIND_ALIVE, 8'd0, 3'd0, 1'b0);
                        else
                        begin
                            for (int i = 0; i < 6; i++)
                                owe_result(KIND_DATA, pattern_byte(i), 3'd0, 1'b0);
                            owe_result(KIND_DATA, c, 3'd0, 1'b0);
                            parse_pending = 1'b1;
                        end
                        parse_phase = PH_STREAM;
                    end
                    default:
                    begin
                        // error phase: drop the byte, report once, go to stream mode
                        owe_result(KIND_ERROR, 8'd0, 3'd0, 1'b0);
                        parse_pending = 1'b0;
                        parse_phase = PH_STREAM;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (parsed_q.size() > n_before)
        begin
            tail = parsed_q[parsed_q.size() - 1];
            tail.last = 1'b1;
            parsed_q[parsed_q.size() - 1] = tail;
        end
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Monitor: sample both handshakes at the clock edge, using the values that
    // the parser saw there. Predict on input transactions, check on output ones.
    always @(posedge clk)
    begin
        res_t exp_res;
        logic took;
        took = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                parse_request(request);
                took = 1'b1;
            end
            if (pop && !empty)
            begin
                took = 1'b1;
                if (parsed_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual kind %0d byte %0d",
                             $time, result.kind, result.byte_out);
                end
                else
                begin
                    exp_res = parsed_q.pop_front();
                    if (result.kind !== exp_res.kind)
                        report_field("kind", exp_res.kind, result.kind);
                    if (result.byte_out !== exp_res.byte_out)
                        report_field("byte_out", exp_res.byte_out, result.byte_out);
                    if (result.field_number !== exp_res.field_number)
                        report_field("field_number", exp_res.field_number,
                                     result.field_number);
                    if (result.after_colon !== exp_res.after_colon)
                        report_field("after_colon", exp_res.after_colon, result.after_colon);
                    if (result.last !== exp_res.last)
                        report_field("last", exp_res.last, result.last);
                end
            end
            // Watchdog: end the run when no transaction moves for too long
            if (took)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: watchdog expired, %0d results outstanding",
                         $time, parsed_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off completely while pop_hold runs down
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold = pop_hold - 1;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Offer one transaction, optionally after a random gap, and return at the
    // edge that accepts it. push stays high for a following item without a gap.
    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        push <= 1'b1;
        request <= {f, b};
        do
            @(posedge clk);
        while (full);
        if (f != FUNC_IGNORED)
            items_sent++;
    endtask

    // Stream-mode traffic: a few data bytes, then a keepalive, a broken
    // keepalive, a flush or nothing.
    task automatic send_stream_segment();
        int         n;
        int         plen;
        logic [7:0] b;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            send_item(FUNC_BYTE, 8'($urandom_range(255)));
        case ($urandom_range(3))
            0:
            begin
                for (int i = 0; i < 6; i++)
                    send_item(FUNC_BYTE, pattern_byte(i));
                send_item(FUNC_BYTE, CH_GT);
            end
            1:
            begin
                plen = $urandom_range(1, 6);
                for (int i = 0; i < plen; i++)
                    send_item(FUNC_BYTE, pattern_byte(i));
                // a break with '<' is weighted in, since it must not restart the match
                b = ($urandom_range(3) == 0) ? CH_LT : 8'($urandom_range(255));
                send_item(FUNC_BYTE, b);
            end
            2:
                send_item(FUNC_FLUSH, 8'($urandom_range(255)));
            default:
            begin
            end
        endcase
    endtask

    // Bad first byte, then the error phase drops one byte and reports
    task automatic test_bad_start();
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, 8'hFF);
    endtask

    // Data in stream mode, flush with and without pending data, unused func
    task automatic test_stream_data();
        send_item(FUNC_BYTE, 8'h7F);
        send_item(FUNC_FLUSH, 8'hFF);
        send_item(FUNC_FLUSH, 8'h00);
        send_item(FUNC_IGNORED, 8'hFF);
    endtask

    task automatic test_keepalive();
        for (int i = 0; i < 6; i++)
            send_item(FUNC_BYTE, pattern_byte(i));
        send_item(FUNC_BYTE, CH_GT);
    endtask

    // Longest replay: full prefix broken by '<'
    task automatic test_broken_keepalive();
        for (int i = 0; i < 6; i++)
            send_item(FUNC_BYTE, pattern_byte(i));
        send_item(FUNC_BYTE, CH_LT);
    endtask

    // Restart, then a login whose separators carry the tags before them
    task automatic test_login();
        send_item(FUNC_RESTART, 8'h00);
        send_item(FUNC_BYTE, CH_LT);
        send_item(FUNC_BYTE, CH_COLON);
        send_item(FUNC_BYTE, CH_SEMI);
        send_item(FUNC_BYTE, CH_SEMI);
        send_item(FUNC_BYTE, CH_SEMI);
        send_item(FUNC_BYTE, CH_GT);
    endtask

    // Hold the receiver off while the sender keeps offering data, so the
    // command queue fills and full holds the input.
    task automatic test_backpressure();
        logic [7:0] b;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_item(FUNC_RESTART, 8'h00);
        send_item(FUNC_BYTE, CH_LT);
        for (int i = 0; i < 3; i++)
            send_item(FUNC_BYTE, CH_SEMI);
        send_item(FUNC_BYTE, CH_GT);
        pop_hold = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            b = 8'($urandom_range(255));
            if (b == CH_LT)
                b = CH_A;
            send_item(FUNC_BYTE, b);
        end
    endtask

    // Random sessions: mostly well-formed logins followed by stream traffic,
    // some bad starts into the error phase, and some raw noise.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        int         stop_at;
        int         target;
        int         nbytes;
        int         r;
        logic [7:0] b;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                if ($urandom_range(1) == 0)
                    send_item(FUNC_RESTART, 8'($urandom_range(255)));
                send_item(FUNC_BYTE, CH_LT);
                // most logins carry exactly three separators; others test
                // reject and the saturating field count
                target = ($urandom_range(3) != 0) ? 3 : $urandom_range(9);
                for (int f = 0; f <= target; f++)
                begin
                    nbytes = $urandom_range(3);
                    for (int i = 0; i < nbytes; i++)
                    begin
                        if ($urandom_range(3) == 0)
                            b = CH_COLON;
                        else
                        begin
                            b = 8'($urandom_range(255));
                            if (b == CH_GT)
                                b = CH_E;
                        end
                        send_item(FUNC_BYTE, b);
                    end
                    if ($urandom_range(15) == 0)
                        send_item(FUNC_FLUSH, 8'($urandom_range(255)));
                    if (f < target)
                        send_item(FUNC_BYTE, CH_SEMI);
                end
                send_item(FUNC_BYTE, CH_GT);
                repeat ($urandom_range(1, 4))
                    send_stream_segment();
                if ($urandom_range(1) == 0)
                    send_item(FUNC_FLUSH, 8'($urandom_range(255)));
            end
            else if (r < 75)
            begin
                send_item(FUNC_RESTART, 8'($urandom_range(255)));
                b = 8'($urandom_range(255));
                if (b == CH_LT)
                    b = CH_GT;
                send_item(FUNC_BYTE, b);
                send_item(FUNC_BYTE, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 3))
                    send_stream_segment();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        // Hold reset low from the start, then release it at an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_start();
        test_stream_data();
        test_keepalive();
        test_broken_keepalive();
        test_login();
        test_backpressure();

        test_random_traffic(45, 0, 0);
        test_random_traffic(45, 79, 0);
        test_random_traffic(45, 0, 79);
        test_random_traffic(45, 19, 19);

        // Drop push, drain what is owed, then let the pipeline settle
        push <= 1'b0;
        pop_stall_pct = 0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
